### rtl/fppc_pkg.sv
// Package for the family phase parity counter: opcodes, status codes, widths.
// No dependencies.
package fppc_pkg;
	localparam int ALLELE_W = 16;
	localparam int MASK_W   = 32;
	localparam int OUT_W    = 32;
	localparam int FAM_W    = 4;
	localparam int IDX_W    = 8;

	typedef enum logic [1:0] {
		OP_PROCESS = 2'd0,
		OP_READ    = 2'd1,
		OP_CLEAR   = 2'd2,
		OP_NONE    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_ACCEPTED   = 2'd0,
		ST_REJECTED   = 2'd1,
		ST_INCONSIST  = 2'd2,
		ST_DONE       = 2'd3
	} status_t;

	// what one child lane reports to the merge stage
	typedef struct packed {
		logic       active;
		logic       bad;
		logic       mom_het;
		logic       dad_het;
		logic       odd;
		logic [3:0] present;
	} lane_t;
endpackage

### rtl/fppc_if.sv
// Valid/ready channel interfaces for the request, result and config ports.
// No dependencies.
interface fppc_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  op;
	logic [15:0] mom_transmitted;
	logic [15:0] mom_untransmitted;
	logic [15:0] dad_transmitted;
	logic [15:0] dad_untransmitted;
	logic [31:0] allele_bad_mask;
	logic [7:0]  counter_index;
	modport source (output valid, op, mom_transmitted, mom_untransmitted, dad_transmitted,
		dad_untransmitted, allele_bad_mask, counter_index, input ready);
	modport sink (input valid, op, mom_transmitted, mom_untransmitted, dad_transmitted,
		dad_untransmitted, allele_bad_mask, counter_index, output ready);
endinterface

interface fppc_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic        father_heterozygous;
	logic [31:0] counter_value;
	logic [31:0] accepted_positions;
	modport source (output valid, status, father_heterozygous, counter_value,
		accepted_positions, input ready);
	modport sink (input valid, status, father_heterozygous, counter_value,
		accepted_positions, output ready);
endinterface

interface fppc_cfg_if;
	logic       valid;
	logic       ready;
	logic [3:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

### rtl/fppc_lane.sv
// One child lane: allele checks, heterozygosity and parity for a single child.
// Depends on fppc_pkg.
module fppc_lane (
	input  logic                 active,
	input  logic [1:0]           mt,
	input  logic [1:0]           mu,
	input  logic [1:0]           dt,
	input  logic [1:0]           du,
	input  logic [3:0]           bad_bits,
	output fppc_pkg::lane_t      lane
);
	import fppc_pkg::*;
	logic mo, dodd;
	always_comb begin
		mo = (mt != mu);
		dodd = (dt != du);
		lane.active  = active;
		lane.bad     = active & ((|bad_bits) | (mo == dodd));
		lane.mom_het = active & mo;
		lane.dad_het = active & dodd;
		lane.odd     = (mt != dt);
		lane.present = active ? ((4'b1 << mt) | (4'b1 << mu) | (4'b1 << dt) | (4'b1 << du))
			: 4'b0;
	end
endmodule

### rtl/fppc_counter.sv
// Saturating counter with synchronous clear; one per child slot, pair slot and the accepted count.
// No dependencies.
module fppc_counter #(
	parameter int WIDTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             clr,
	input  logic             inc,
	output logic [WIDTH-1:0] value
);
	logic [WIDTH-1:0] cnt_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (clr) begin
			cnt_q <= '0;
		end else if (inc && !(&cnt_q)) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end
	assign value = cnt_q;
endmodule

### rtl/family_phase_parity_counter.sv
// Top level: child lanes, merge stage, counter banks and output register.
// Depends on fppc_pkg, fppc_if, fppc_lane, fppc_counter.
//
//  channel | dir | carries
//  req     | in  | op, four allele words, bad mask, counter index
//  rsp     | out | status, father_heterozygous, counter_value, accepted_positions
//  cfg     | in  | family_size
//
// One request per cycle. Stage 1 registers the lane results; stage 2 merges them,
// updates the counters and loads the output register, so each result is registered first
// in stage 1 and then in the output register. The pipeline advances when the output
// register is empty or taken. Reset clears all counters at once and sets family_size to 1.
module family_phase_parity_counter #(
	parameter int MAX_CHILDREN = 8,
	parameter int COUNT_WIDTH  = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	fppc_req_if.sink   req,
	fppc_rsp_if.source rsp,
	fppc_cfg_if.sink   cfg
);
	import fppc_pkg::*;
	localparam int NP = MAX_CHILDREN * (MAX_CHILDREN - 1) / 2;
	localparam int NPS = (NP > 0) ? NP * 8 : 1;

	logic [FAM_W-1:0] fam_q;
	logic [FAM_W-1:0] n_eff;
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) fam_q <= FAM_W'(1);
		else if (cfg.valid) fam_q <= cfg.data;
	end
	assign n_eff = (fam_q > FAM_W'(MAX_CHILDREN)) ? FAM_W'(MAX_CHILDREN) : fam_q;

	logic adv;
	logic v_s1, v_s2;
	assign adv = !v_s2 || rsp.ready;
	assign req.ready = adv;

	lane_t lanes [MAX_CHILDREN];
	lane_t lanes_s1 [MAX_CHILDREN];
	op_t   op_s1;
	logic [IDX_W-1:0] idx_s1;

	for (genvar i = 0; i < MAX_CHILDREN; i++) begin : g_lane
		fppc_lane u_lane (
			.active   (FAM_W'(i) < n_eff),
			.mt       (req.mom_transmitted[2*i +: 2]),
			.mu       (req.mom_untransmitted[2*i +: 2]),
			.dt       (req.dad_transmitted[2*i +: 2]),
			.du       (req.dad_untransmitted[2*i +: 2]),
			.bad_bits (req.allele_bad_mask[4*i +: 4]),
			.lane     (lanes[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (adv) v_s1 <= req.valid;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			lanes_s1 <= lanes;
			op_s1    <= op_t'(req.op);
			idx_s1   <= req.counter_index;
		end
	end

	// merge stage
	logic       any_bad, saw_mom, saw_dad, any_act, ok, acc, dhet, clr;
	logic [3:0] present;
	logic [2:0] ndist;
	status_t    st;
	always_comb begin
		any_bad = 1'b0; saw_mom = 1'b0; saw_dad = 1'b0; any_act = 1'b0; present = '0;
		for (int i = 0; i < MAX_CHILDREN; i++) begin
			any_bad |= lanes_s1[i].bad;
			saw_mom |= lanes_s1[i].mom_het;
			saw_dad |= lanes_s1[i].dad_het;
			any_act |= lanes_s1[i].active;
			present |= lanes_s1[i].present;
		end
		ndist = 3'(present[0]) + 3'(present[1]) + 3'(present[2]) + 3'(present[3]);
		ok = any_act && !any_bad && (ndist == 3'd2);
		dhet = saw_dad;
		acc = 1'b0;
		st = ST_DONE;
		case (op_s1)
			OP_PROCESS: begin
				if (!ok) st = ST_REJECTED;
				else if (saw_mom && saw_dad) st = ST_INCONSIST;
				else begin
					st = ST_ACCEPTED;
					acc = 1'b1;
				end
			end
			default: st = ST_DONE;
		endcase
		acc = acc && v_s1 && adv;
		clr = v_s1 && adv && (op_s1 == OP_CLEAR);
	end

	logic [COUNT_WIDTH-1:0] child_val [MAX_CHILDREN*4];
	logic [COUNT_WIDTH-1:0] pair_val [NPS];
	logic [COUNT_WIDTH-1:0] acc_val;

	for (genvar i = 0; i < MAX_CHILDREN; i++) begin : g_child
		for (genvar s = 0; s < 4; s++) begin : g_slot
			fppc_counter #(.WIDTH(COUNT_WIDTH)) u_cnt (
				.clk (clk), .arst_n (arst_n), .clr (clr),
				.inc (acc && lanes_s1[i].active && ({lanes_s1[i].odd, dhet} == 2'(s))),
				.value (child_val[i*4+s])
			);
		end
	end

	for (genvar i = 0; i < MAX_CHILDREN; i++) begin : g_pi
		for (genvar j = i + 1; j < MAX_CHILDREN; j++) begin : g_pj
			localparam int PN = i * (2 * MAX_CHILDREN - i - 1) / 2 + (j - i - 1);
			for (genvar s = 0; s < 8; s++) begin : g_ps
				fppc_counter #(.WIDTH(COUNT_WIDTH)) u_cnt (
					.clk (clk), .arst_n (arst_n), .clr (clr),
					.inc (acc && lanes_s1[j].active &&
						({(lanes_s1[i].odd == lanes_s1[j].odd), lanes_s1[i].odd, dhet}
						== 3'(s))),
					.value (pair_val[PN*8+s])
				);
			end
		end
	end
	if (NP == 0) begin : g_nopair
		assign pair_val[0] = '0;
	end

	fppc_counter #(.WIDTH(COUNT_WIDTH)) u_acc (
		.clk (clk), .arst_n (arst_n), .clr (clr), .inc (acc), .value (acc_val)
	);

	// read mux; accepted count reflects this request's own update
	logic [COUNT_WIDTH-1:0] rd_val;
	logic [COUNT_WIDTH-1:0] acc_next;
	logic [IDX_W-1:0]       pidx;
	always_comb begin
		rd_val = '0;
		pidx = idx_s1 - IDX_W'(32);
		if (op_s1 == OP_READ) begin
			if (idx_s1 < IDX_W'(32)) begin
				if (32'(idx_s1) < 32'(MAX_CHILDREN * 4)) rd_val = child_val[idx_s1[4:0]];
			end else if (NP > 0 && 32'(pidx) < 32'(NPS)) begin
				rd_val = pair_val[pidx];
			end
		end
		if (clr) acc_next = '0;
		else if (acc && !(&acc_val)) acc_next = acc_val + 1'b1;
		else acc_next = acc_val;
	end

	logic [1:0]        st_s2;
	logic              fh_s2;
	logic [OUT_W-1:0]  cv_s2, ap_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (adv) v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			st_s2 <= st;
			fh_s2 <= (st == ST_ACCEPTED) && (op_s1 == OP_PROCESS) && dhet;
			cv_s2 <= OUT_W'(rd_val);
			ap_s2 <= OUT_W'(acc_next);
		end
	end
	assign rsp.valid = v_s2;
	assign rsp.status = st_s2;
	assign rsp.father_heterozygous = fh_s2;
	assign rsp.counter_value = cv_s2;
	assign rsp.accepted_positions = ap_s2;
endmodule

### verif/tb.sv
// Self-checking testbench for family_phase_parity_counter: directed and random requests,
// random stalls on both channels, family_size changes between phases.
// Depends on fppc_pkg, fppc_if and the block's RTL.
module tb;
	import fppc_pkg::*;

	typedef struct {
		logic [1:0]  status;
		logic        father_het;
		logic [31:0] value;
		logic [31:0] accepted;
	} tally_rsp_t;

	typedef struct {
		op_t         op;
		logic [15:0] mt, mu, dt, du;
		logic [31:0] bad;
		logic [7:0]  idx;
	} pos_req_t;

	class parity_tally;
		logic [31:0] child_cnt[32];
		logic [31:0] pair_cnt[224];
		logic [31:0] accepted;
		logic [3:0]  fam_size;
		tally_rsp_t  pending[$];
		int          errors;

		function new();
			wipe();
			fam_size = 4'd1;
			errors = 0;
		endfunction

		function void wipe();
			foreach (child_cnt[k]) child_cnt[k] = '0;
			foreach (pair_cnt[k]) pair_cnt[k] = '0;
			accepted = '0;
		endfunction

		function logic [31:0] sat_inc(logic [31:0] c);
			return (c == 32'hFFFF_FFFF) ? c : c + 32'd1;
		endfunction

		function void note_request(pos_req_t r);
			tally_rsp_t e;
			int n, share, slot, d, cs;
			logic ok, saw_mom, saw_dad, m_odd, d_odd;
			logic [1:0] a_mt, a_mu, a_dt, a_du;
			logic [3:0] present;
			logic [7:0] odd;
			e.status = ST_DONE;
			e.father_het = 1'b0;
			e.value = '0;
			case (r.op)
				OP_PROCESS: begin
					n = (fam_size > 8) ? 8 : int'(fam_size);
					ok = (n > 0);
					saw_mom = 1'b0;
					saw_dad = 1'b0;
					present = '0;
					odd = '0;
					for (int i = 0; i < n; i++) begin
						a_mt = r.mt[2*i +: 2];
						a_mu = r.mu[2*i +: 2];
						a_dt = r.dt[2*i +: 2];
						a_du = r.du[2*i +: 2];
						m_odd = (a_mt != a_mu);
						d_odd = (a_dt != a_du);
						if (r.bad[4*i +: 4] != 4'd0) ok = 1'b0;
						present[a_mt] = 1'b1;
						present[a_mu] = 1'b1;
						present[a_dt] = 1'b1;
						present[a_du] = 1'b1;
						if (m_odd) saw_mom = 1'b1;
						if (d_odd) saw_dad = 1'b1;
						if (m_odd == d_odd) ok = 1'b0;
						odd[i] = (a_mt != a_dt);
					end
					if ($countones(present) != 2) ok = 1'b0;
					if (!ok) begin
						e.status = ST_REJECTED;
					end else if (saw_mom && saw_dad) begin
						e.status = ST_INCONSIST;
					end else begin
						d = int'(saw_dad);
						e.status = ST_ACCEPTED;
						e.father_het = saw_dad;
						for (int i = 0; i < n; i++) begin
							cs = i*4 + int'(odd[i])*2 + d;
							child_cnt[cs[4:0]] = sat_inc(child_cnt[cs[4:0]]);
							for (int j = i + 1; j < n; j++) begin
								share = int'(odd[i] == odd[j]);
								slot = (i * (15 - i) / 2 + (j - i - 1)) * 8 + share*4
									+ int'(odd[i])*2 + d;
								pair_cnt[slot[7:0]] = sat_inc(pair_cnt[slot[7:0]]);
							end
						end
						accepted = sat_inc(accepted);
					end
				end
				OP_READ: begin
					if (r.idx < 8'd32) e.value = child_cnt[r.idx[4:0]];
					else e.value = pair_cnt[8'(r.idx - 8'd32)];
				end
				OP_CLEAR: wipe();
				default: ;
			endcase
			e.accepted = accepted;
			pending.insert(pending.size(), e);
		endfunction

		function void check_response(tally_rsp_t got);
			tally_rsp_t e;
			if (pending.size() == 0) begin
				$error("response with nothing outstanding");
				errors++;
				return;
			end
			e = pending.pop_front();
			if (got.status !== e.status) begin
				$error("status: expected %0d, got %0d", e.status, got.status);
				errors++;
			end
			if (got.father_het !== e.father_het) begin
				$error("father_heterozygous: expected %0d, got %0d", e.father_het,
					got.father_het);
				errors++;
			end
			if (got.value !== e.value) begin
				$error("counter_value: expected %0d, got %0d", e.value, got.value);
				errors++;
			end
			if (got.accepted !== e.accepted) begin
				$error("accepted_positions: expected %0d, got %0d", e.accepted, got.accepted);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	fppc_req_if req_ch();
	fppc_rsp_if rsp_ch();
	fppc_cfg_if cfg_ch();

	family_phase_parity_counter i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch.sink),
		.rsp   (rsp_ch.source),
		.cfg   (cfg_ch.sink)
	);

	parity_tally tally = new();
	bit quiet;
	bit hold_rsp;
	int cycles;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > 400000) begin
			$display("[family_phase_parity_counter] ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		pos_req_t r;
		tally_rsp_t g;
		if (arst_n && req_ch.valid && req_ch.ready) begin
			r.op = op_t'(req_ch.op);
			r.mt = req_ch.mom_transmitted;
			r.mu = req_ch.mom_untransmitted;
			r.dt = req_ch.dad_transmitted;
			r.du = req_ch.dad_untransmitted;
			r.bad = req_ch.allele_bad_mask;
			r.idx = req_ch.counter_index;
			tally.note_request(r);
		end
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			g.status = rsp_ch.status;
			g.father_het = rsp_ch.father_heterozygous;
			g.value = rsp_ch.counter_value;
			g.accepted = rsp_ch.accepted_positions;
			tally.check_response(g);
		end
	end

	// response side: random stall bursts, one long hold on request
	initial begin
		int len;
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_rsp) begin
				hold_rsp = 1'b0;
				rsp_ch.ready <= 1'b0;
				repeat (300) @(posedge clk);
			end else begin
				len = $urandom_range(1, 15);
				rsp_ch.ready <= quiet || ($urandom_range(0, 3) != 0);
				repeat (len - 1) @(posedge clk);
			end
		end
	end

	task automatic send_req(pos_req_t r);
		req_ch.valid <= 1'b1;
		req_ch.op <= r.op;
		req_ch.mom_transmitted <= r.mt;
		req_ch.mom_untransmitted <= r.mu;
		req_ch.dad_transmitted <= r.dt;
		req_ch.dad_untransmitted <= r.du;
		req_ch.allele_bad_mask <= r.bad;
		req_ch.counter_index <= r.idx;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
	endtask

	task automatic set_family_size(logic [3:0] v);
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (tally.pending.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= v;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		tally.fam_size = v;
		cfg_ch.valid <= 1'b0;
	endtask

	// two alleles a/b; the het parent carries both, the other a single one
	function automatic pos_req_t family_pos(bit dad_het, int flips);
		pos_req_t r;
		logic [1:0] a, b, h0, h1, hom;
		bit het;
		a = 2'($urandom_range(0, 3));
		b = a + 2'($urandom_range(1, 3));
		r.op = OP_PROCESS;
		r.bad = '0;
		r.idx = 8'($urandom);
		r.mt = 16'($urandom);
		r.mu = 16'($urandom);
		r.dt = 16'($urandom);
		r.du = 16'($urandom);
		for (int i = 0; i < 8; i++) begin
			het = (flips > 0 && i == $urandom_range(0, 7)) ? !dad_het : dad_het;
			if (i == 1 && flips > 0) het = !dad_het;
			if ($urandom_range(0, 1)) begin h0 = a; h1 = b; end
			else begin h0 = b; h1 = a; end
			hom = $urandom_range(0, 1) ? a : b;
			if (het) begin
				r.dt[2*i +: 2] = h0;
				r.du[2*i +: 2] = h1;
				r.mt[2*i +: 2] = hom;
				r.mu[2*i +: 2] = hom;
			end else begin
				r.mt[2*i +: 2] = h0;
				r.mu[2*i +: 2] = h1;
				r.dt[2*i +: 2] = hom;
				r.du[2*i +: 2] = hom;
			end
		end
		return r;
	endfunction

	function automatic pos_req_t other_req(op_t op);
		pos_req_t r;
		r.op = op;
		r.mt = 16'($urandom);
		r.mu = 16'($urandom);
		r.dt = 16'($urandom);
		r.du = 16'($urandom);
		r.bad = $urandom;
		r.idx = 8'($urandom);
		return r;
	endfunction

	task automatic random_req();
		pos_req_t r;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 58) begin
			r = family_pos(1'($urandom_range(0, 1)), 0);
		end else if (pick < 66) begin
			r = family_pos(1'($urandom_range(0, 1)), 1);
		end else if (pick < 72) begin
			r = family_pos(1'($urandom_range(0, 1)), 0);
			r.bad[5'($urandom_range(0, 31))] = 1'b1;
		end else if (pick < 76) begin
			r = family_pos(1'($urandom_range(0, 1)), 0);
			r.mt[2*$urandom_range(0, 7) +: 2] = 2'($urandom);
		end else if (pick < 82) begin
			r = other_req(OP_PROCESS);
			if ($urandom_range(0, 1)) r.bad = '0;
		end else if (pick < 97) begin
			r = other_req(OP_READ);
		end else if (pick < 98) begin
			r = other_req(OP_CLEAR);
		end else begin
			r = other_req(OP_NONE);
		end
		send_req(r);
	endtask

	initial begin
		pos_req_t r;
		logic [3:0] sizes[11] = '{4'd8, 4'd1, 4'd0, 4'd15, 4'd2, 4'd5, 4'd3, 4'd7, 4'd4,
			4'd6, 4'd8};
		arst_n = 1'b0;
		quiet = 1'b0;
		hold_rsp = 1'b0;
		cycles = 0;
		req_ch.valid = 1'b0;
		req_ch.op = OP_NONE;
		req_ch.mom_transmitted = '0;
		req_ch.mom_untransmitted = '0;
		req_ch.dad_transmitted = '0;
		req_ch.dad_untransmitted = '0;
		req_ch.allele_bad_mask = '0;
		req_ch.counter_index = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: default size 1, then full family
		send_req(family_pos(1'b1, 0));
		send_req(other_req(OP_READ));
		set_family_size(4'd8);
		send_req(other_req(OP_CLEAR));
		send_req(family_pos(1'b0, 0));
		send_req(family_pos(1'b1, 0));
		send_req(family_pos(1'b1, 1));
		r = family_pos(1'b0, 0);
		r.bad = 32'h8000_0000;
		send_req(r);
		r = family_pos(1'b0, 0);
		r.bad = 32'h0000_0001;
		send_req(r);
		r = family_pos(1'b1, 0);
		r.mt = 16'hFFFF;
		r.mu = 16'h0000;
		send_req(r);
		r = family_pos(1'b0, 0);
		r.du[1:0] = r.dt[1:0] + 2'd1;
		send_req(r);
		send_req(other_req(OP_NONE));
		for (int k = 0; k < 4; k++) begin
			r = other_req(OP_READ);
			r.idx = (k == 0) ? 8'd0 : (k == 1) ? 8'd31 : (k == 2) ? 8'd32 : 8'd255;
			send_req(r);
		end
		r = other_req(OP_PROCESS);
		r.mt = 16'h0000;
		r.mu = 16'h0000;
		r.dt = 16'h0000;
		r.du = 16'h0000;
		r.bad = '0;
		send_req(r);
		send_req(other_req(OP_CLEAR));
		send_req(family_pos(1'b1, 0));

		foreach (sizes[p]) begin
			set_family_size(sizes[p]);
			if (p == 3) hold_rsp = 1'b1;
			if (p == 10) quiet = 1'b1;
			repeat (40) random_req();
		end

		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (tally.pending.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (tally.errors == 0 && tally.pending.size() == 0)
			$display("[family_phase_parity_counter] OK");
		else
			$display("[family_phase_parity_counter] ERROR");
		$finish;
	end
endmodule
